/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/cct_pkg.sv */
// ---------------------------------------------------------------------------
// cct_pkg
// Types and constants of the convolutional code trellis stepper
// ---------------------------------------------------------------------------
package cct_pkg;

	localparam int MAX_STREAMS  = 2;
	localparam int MAX_OUTPUTS  = 4;
	localparam int MAX_DEGREE   = 8;
	localparam int SLOT         = MAX_DEGREE + 1;
	localparam int GEN_W        = MAX_STREAMS * SLOT;
	localparam int STREAM_CNT_W = 2;
	localparam int OUT_CNT_W    = 3;
	localparam int STATE_W      = 16;
	localparam int DEG_W        = $clog2(SLOT);
	localparam int STREAM_IDX_W = $clog2(MAX_STREAMS);
	localparam int OUT_IDX_W    = $clog2(MAX_OUTPUTS);
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = GEN_W;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_NUM_IN_STREAMS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_OUT_BITS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_OUT0       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_OUT1       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_OUT2       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_OUT3       = 3'd5;

	// reset values
	localparam logic [STREAM_CNT_W-1:0] RST_NUM_IN_STREAMS = 2'd1;
	localparam logic [OUT_CNT_W-1:0]    RST_NUM_OUT_BITS   = 3'd2;
	localparam logic [GEN_W-1:0]        RST_GEN_OUT0       = 18'd7;
	localparam logic [GEN_W-1:0]        RST_GEN_OUT1       = 18'd5;

	typedef logic [MAX_STREAMS-1:0][MAX_DEGREE-1:0] sreg_t;

	typedef struct packed {
		logic [STREAM_CNT_W-1:0]           num_in_streams;
		logic [OUT_CNT_W-1:0]              num_out_bits;
		logic [MAX_OUTPUTS-1:0][GEN_W-1:0] gen;
	} cfg_t;

	typedef struct packed {
		logic [MAX_OUTPUTS-1:0] out_symbol;
		logic [STATE_W-1:0]     next_state_index;
		logic                   config_error;
	} result_t;

endpackage

/* src/cct_step.sv */
// ---------------------------------------------------------------------------
// cct_step
// One trellis step: output symbol, next stream registers and state index
// ---------------------------------------------------------------------------
module cct_step (
	input  cct_pkg::cfg_t                       cfg,
	input  logic [cct_pkg::MAX_STREAMS-1:0]     symbol,
	input  cct_pkg::sreg_t                      sreg,
	output cct_pkg::sreg_t                      sreg_next,
	output cct_pkg::result_t                    result,
	output logic                                single_stream
);

	logic [cct_pkg::STREAM_CNT_W-1:0]                         k_eff;
	logic [cct_pkg::OUT_CNT_W-1:0]                            n_eff;
	logic [cct_pkg::MAX_STREAMS-1:0]                          active;
	logic [cct_pkg::MAX_STREAMS-1:0][cct_pkg::SLOT-1:0]       poly_or;
	logic [cct_pkg::MAX_STREAMS-1:0][cct_pkg::DEG_W-1:0]      mem;
	logic [cct_pkg::MAX_STREAMS-1:0][cct_pkg::SLOT-1:0]       tx;
	logic [cct_pkg::MAX_STREAMS-1:0]                          in_bit;
	logic [cct_pkg::MAX_OUTPUTS-1:0]                          obit;
	logic [cct_pkg::MAX_OUTPUTS-1:0]                          osym;
	logic [cct_pkg::STATE_W-1:0]                              state;
	logic                                                     err;

	// clamp stream and output counts
	always_comb begin
		if (cfg.num_in_streams == '0)
			k_eff = cct_pkg::STREAM_CNT_W'(1);
		else if (cfg.num_in_streams > cct_pkg::STREAM_CNT_W'(cct_pkg::MAX_STREAMS))
			k_eff = cct_pkg::STREAM_CNT_W'(cct_pkg::MAX_STREAMS);
		else
			k_eff = cfg.num_in_streams;
		if (cfg.num_out_bits == '0)
			n_eff = cct_pkg::OUT_CNT_W'(1);
		else if (cfg.num_out_bits > cct_pkg::OUT_CNT_W'(cct_pkg::MAX_OUTPUTS))
			n_eff = cct_pkg::OUT_CNT_W'(cct_pkg::MAX_OUTPUTS);
		else
			n_eff = cfg.num_out_bits;
	end

	assign single_stream = (k_eff == cct_pkg::STREAM_CNT_W'(1));

	// memory depth per stream
	always_comb begin
		err = 1'b0;
		for (int j = 0; j < cct_pkg::MAX_STREAMS; j++) begin
			active[j]  = (cct_pkg::STREAM_CNT_W'(j) < k_eff);
			poly_or[j] = '0;
			for (int i = 0; i < cct_pkg::MAX_OUTPUTS; i++) begin
				if (cct_pkg::OUT_CNT_W'(i) < n_eff)
					poly_or[j] = poly_or[j] | cfg.gen[i][cct_pkg::SLOT*j +: cct_pkg::SLOT];
			end
			mem[j] = '0;
			for (int b = 0; b < cct_pkg::SLOT; b++) begin
				if (poly_or[j][b])
					mem[j] = cct_pkg::DEG_W'(b);
			end
			if (active[j] && poly_or[j] == '0)
				err = 1'b1;
		end
	end

	// transition words
	always_comb begin
		for (int j = 0; j < cct_pkg::MAX_STREAMS; j++) begin
			logic [cct_pkg::STREAM_CNT_W-1:0] pos;
			logic [cct_pkg::SLOT-1:0]         mask;
			pos       = k_eff - cct_pkg::STREAM_CNT_W'(j) - cct_pkg::STREAM_CNT_W'(1);
			in_bit[j] = active[j] & symbol[pos[cct_pkg::STREAM_IDX_W-1:0]];
			mask      = cct_pkg::SLOT'((1 << mem[j]) - 1);
			tx[j]     = (cct_pkg::SLOT'(in_bit[j]) << mem[j]) | ({1'b0, sreg[j]} & mask);
		end
	end

	// coded bits, output 0 most significant
	always_comb begin
		osym = '0;
		for (int i = 0; i < cct_pkg::MAX_OUTPUTS; i++) begin
			logic [cct_pkg::OUT_CNT_W-1:0] pos;
			obit[i] = 1'b0;
			for (int j = 0; j < cct_pkg::MAX_STREAMS; j++) begin
				if (active[j])
					obit[i] = obit[i] ^ (^(cfg.gen[i][cct_pkg::SLOT*j +: cct_pkg::SLOT] & tx[j]));
			end
			pos = n_eff - cct_pkg::OUT_CNT_W'(i) - cct_pkg::OUT_CNT_W'(1);
			if (cct_pkg::OUT_CNT_W'(i) < n_eff)
				osym[pos[cct_pkg::OUT_IDX_W-1:0]] = obit[i];
		end
	end

	// register update and mixed radix index
	always_comb begin
		state = '0;
		for (int j = 0; j < cct_pkg::MAX_STREAMS; j++) begin
			if (active[j] && !err) begin
				sreg_next[j] = tx[j][cct_pkg::SLOT-1:1];
				state        = (state << mem[j]) | cct_pkg::STATE_W'(sreg_next[j]);
			end else begin
				sreg_next[j] = sreg[j];
			end
		end
	end

	assign result.out_symbol       = err ? '0 : osym;
	assign result.next_state_index = err ? '0 : state;
	assign result.config_error     = err;

endmodule

/* src/conv_code_trellis_step_core.sv */
// ---------------------------------------------------------------------------
// conv_code_trellis_step_core
// Binary (n,k) conv. code trellis stepper, one symbol per unstalled cycle
// ---------------------------------------------------------------------------
// Usage:
//  - input channel in_valid / in_stall carries in_symbol, k bits per request
//  - output channel out_valid / out_stall carries out_symbol,
//    next_state_index and config_error, one result per input request
//  - configuration is written through cfg_wr_en / cfg_index / cfg_wdata;
//    the user must write it only while the block is idle, which the block
//    does not enforce; registers take effect on the next request
//  - a request is held in the input register, the step logic runs between
//    it and the result register, which loads the result when not stalled
//  - throughput is one request per cycle while the output is not stalled,
//    set by the single xor and shift step feeding the result register
//  - when the receiver stalls, the result holds and one more request is
//    taken into the input register before in_stall rises
//  - reset clears both stream registers and loads the default code
//    (k = 1, n = 2, polynomials 7 and 5)
//  - an all-zero active stream gives config_error with zero outputs and
//    leaves the stream registers unchanged
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module conv_code_trellis_step_core (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_wr_en,
	input  logic [cct_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cct_pkg::CFG_DATA_W-1:0]      cfg_wdata,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cct_pkg::MAX_STREAMS-1:0]     in_symbol,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cct_pkg::MAX_OUTPUTS-1:0]     out_symbol,
	output logic [cct_pkg::STATE_W-1:0]         next_state_index,
	output logic                                config_error
);

	cct_pkg::cfg_t                        cfg_q;
	cct_pkg::sreg_t                       sreg_q;
	cct_pkg::sreg_t                       sreg_next;
	cct_pkg::result_t                     result;
	cct_pkg::result_t                     result_q;
	logic                                 single_stream;
	logic                                 valid_s1;
	logic [cct_pkg::MAX_STREAMS-1:0]      symbol_s1;
	logic                                 out_valid_q;
	logic                                 advance;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_in_streams <= cct_pkg::RST_NUM_IN_STREAMS;
			cfg_q.num_out_bits   <= cct_pkg::RST_NUM_OUT_BITS;
			cfg_q.gen[0]         <= cct_pkg::RST_GEN_OUT0;
			cfg_q.gen[1]         <= cct_pkg::RST_GEN_OUT1;
			cfg_q.gen[2]         <= '0;
			cfg_q.gen[3]         <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cct_pkg::REG_NUM_IN_STREAMS: begin
					cfg_q.num_in_streams <= cfg_wdata[cct_pkg::STREAM_CNT_W-1:0];
				end
				cct_pkg::REG_NUM_OUT_BITS: begin
					cfg_q.num_out_bits <= cfg_wdata[cct_pkg::OUT_CNT_W-1:0];
				end
				cct_pkg::REG_GEN_OUT0: begin
					cfg_q.gen[0] <= cfg_wdata;
				end
				cct_pkg::REG_GEN_OUT1: begin
					cfg_q.gen[1] <= cfg_wdata;
				end
				cct_pkg::REG_GEN_OUT2: begin
					cfg_q.gen[2] <= cfg_wdata;
				end
				cct_pkg::REG_GEN_OUT3: begin
					cfg_q.gen[3] <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			symbol_s1 <= in_symbol;
	end

	cct_step u_step (
		.cfg           (cfg_q),
		.symbol        (symbol_s1),
		.sreg          (sreg_q),
		.sreg_next     (sreg_next),
		.result        (result),
		.single_stream (single_stream)
	);

	// stream registers and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sreg_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1)
				sreg_q <= sreg_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			result_q <= result;
	end

	assign out_valid        = out_valid_q;
	assign out_symbol       = result_q.out_symbol;
	assign next_state_index = result_q.next_state_index;
	assign config_error     = result_q.config_error;

	`ASSERT_IMPL(a_err_zero_out, clk, arst_n, out_valid && config_error,
		out_symbol == '0 && next_state_index == '0, "error result carries data")
	`ASSERT_NEXT(a_err_holds_state, clk, arst_n, advance && valid_s1 && result.config_error,
		$stable(sreg_q), "stream registers moved on an error request")
	`ASSERT_IMPL(a_one_stream_index, clk, arst_n, out_valid && single_stream,
		next_state_index[cct_pkg::STATE_W-1:cct_pkg::MAX_DEGREE] == '0,
		"state index wider than one stream")
	`ASSERT_NEXT(a_stalled_request_held, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(symbol_s1), "request lost in input register")

endmodule

/* tb/conv_code_trellis_step_core_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conv_code_trellis_step_core_test
// Self-checking bench for the trellis stepper: a queue-fed driver sends input
// symbols with random gaps, a monitor takes results under random stall and
// compares them against an in-bench encoder model. The code configuration is
// rewritten between phases once the block has drained, covering clamped
// counts, maximum memory depth and all-zero streams.
// ---------------------------------------------------------------------------
module conv_code_trellis_step_core_test;

	localparam int RANDOM_REQUESTS = 1400;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_wr_en = 1'b0;
	logic [cct_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [cct_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	logic [cct_pkg::MAX_STREAMS-1:0] in_symbol = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [cct_pkg::MAX_OUTPUTS-1:0] out_symbol;
	logic [cct_pkg::STATE_W-1:0]     next_state_index;
	logic                            config_error;

	// encoder model: configuration and stream registers
	logic [cct_pkg::STREAM_CNT_W-1:0] code_k;
	logic [cct_pkg::OUT_CNT_W-1:0]    code_n;
	logic [cct_pkg::GEN_W-1:0]        code_gen [cct_pkg::MAX_OUTPUTS];
	logic [cct_pkg::MAX_DEGREE-1:0]   enc_reg [cct_pkg::MAX_STREAMS];

	logic [cct_pkg::MAX_STREAMS-1:0] symbols_to_send [$];
	cct_pkg::result_t                expected_results [$];

	int send_gap   = 0;
	int recv_left  = 0;
	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;
	int fail_count = 0;

	conv_code_trellis_step_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_symbol        (in_symbol),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_symbol       (out_symbol),
		.next_state_index (next_state_index),
		.config_error     (config_error)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic cct_pkg::result_t encode_symbol(
		input logic [cct_pkg::MAX_STREAMS-1:0] sym);
		int                              k;
		int                              n;
		int                              mem [cct_pkg::MAX_STREAMS];
		logic [cct_pkg::MAX_DEGREE:0]    tx [cct_pkg::MAX_STREAMS];
		logic [cct_pkg::MAX_DEGREE:0]    poly;
		logic [cct_pkg::MAX_DEGREE:0]    mask;
		logic [cct_pkg::MAX_OUTPUTS-1:0] osym;
		logic [cct_pkg::STATE_W-1:0]     st;
		logic                            par;
		bit                              err;
		cct_pkg::result_t                r;
		k = (code_k < 1) ? 1 :
			((code_k > cct_pkg::MAX_STREAMS) ? cct_pkg::MAX_STREAMS : int'(code_k));
		n = (code_n < 1) ? 1 :
			((code_n > cct_pkg::MAX_OUTPUTS) ? cct_pkg::MAX_OUTPUTS : int'(code_n));
		err = 1'b0;
		for (int j = 0; j < k; j++) begin
			mem[j] = -1;
			for (int i = 0; i < n; i++) begin
				poly = code_gen[i][j*cct_pkg::SLOT +: cct_pkg::SLOT];
				for (int b = 0; b < cct_pkg::SLOT; b++)
					if (poly[b] && b > mem[j])
						mem[j] = b;
			end
			if (mem[j] < 0)
				err = 1'b1;
		end
		if (err) begin
			r.out_symbol       = '0;
			r.next_state_index = '0;
			r.config_error     = 1'b1;
			return r;
		end
		for (int j = 0; j < k; j++) begin
			mask  = ({{cct_pkg::MAX_DEGREE{1'b0}}, 1'b1} << mem[j]) - 1'b1;
			tx[j] = ({{cct_pkg::MAX_DEGREE{1'b0}}, sym[k-1-j]} << mem[j])
				| ({1'b0, enc_reg[j]} & mask);
		end
		osym = '0;
		for (int i = 0; i < n; i++) begin
			par = 1'b0;
			for (int j = 0; j < k; j++) begin
				poly = code_gen[i][j*cct_pkg::SLOT +: cct_pkg::SLOT];
				par  = par ^ (^(poly & tx[j]));
			end
			osym = {osym[cct_pkg::MAX_OUTPUTS-2:0], par};
		end
		st = '0;
		for (int j = 0; j < k; j++) begin
			enc_reg[j] = tx[j][cct_pkg::MAX_DEGREE:1];
			st = (st << mem[j]) | cct_pkg::STATE_W'(enc_reg[j]);
		end
		r.out_symbol       = osym;
		r.next_state_index = st;
		r.config_error     = 1'b0;
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			in_symbol <= '0;
			send_gap  <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(encode_symbol(in_symbol));
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap  <= send_gap - 1;
					in_valid  <= 1'b0;
					in_symbol <= 2'($urandom_range(0, 3));
				end else if (symbols_to_send.size() != 0) begin
					in_valid  <= 1'b1;
					in_symbol <= symbols_to_send.pop_front();
					if ($urandom_range(0, 31) == 0)
						send_burst = ~send_burst;
					send_gap  <= draw_wait(send_burst);
				end else begin
					in_valid  <= 1'b0;
					in_symbol <= 2'($urandom_range(0, 3));
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		int               left;
		cct_pkg::result_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_left <= 0;
		end else begin
			left = (recv_left > 0) ? recv_left - 1 : 0;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: out_symbol %0h state %0h error %0b",
						out_symbol, next_state_index, config_error);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (out_symbol !== exp_r.out_symbol) begin
						$error("out_symbol: expected %0h, got %0h", exp_r.out_symbol, out_symbol);
						fail_count++;
					end
					if (next_state_index !== exp_r.next_state_index) begin
						$error("next_state_index: expected %0h, got %0h",
							exp_r.next_state_index, next_state_index);
						fail_count++;
					end
					if (config_error !== exp_r.config_error) begin
						$error("config_error: expected %0b, got %0b",
							exp_r.config_error, config_error);
						fail_count++;
					end
				end
				if ($urandom_range(0, 31) == 0)
					recv_burst = ~recv_burst;
				left = draw_wait(recv_burst);
			end
			recv_left <= left;
			out_stall <= (left != 0);
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (symbols_to_send.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cct_pkg::CFG_IDX_W-1:0] idx,
		input logic [cct_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			cct_pkg::REG_NUM_IN_STREAMS: code_k = data[cct_pkg::STREAM_CNT_W-1:0];
			cct_pkg::REG_NUM_OUT_BITS:   code_n = data[cct_pkg::OUT_CNT_W-1:0];
			cct_pkg::REG_GEN_OUT0:       code_gen[0] = data;
			cct_pkg::REG_GEN_OUT1:       code_gen[1] = data;
			cct_pkg::REG_GEN_OUT2:       code_gen[2] = data;
			cct_pkg::REG_GEN_OUT3:       code_gen[3] = data;
			default: ;
		endcase
	endtask

	// pauses the sender until the block has drained, then loads a new code
	task automatic load_code(input logic [cct_pkg::CFG_DATA_W-1:0] kw,
		input logic [cct_pkg::CFG_DATA_W-1:0] nw,
		input logic [cct_pkg::CFG_DATA_W-1:0] g0, input logic [cct_pkg::CFG_DATA_W-1:0] g1,
		input logic [cct_pkg::CFG_DATA_W-1:0] g2, input logic [cct_pkg::CFG_DATA_W-1:0] g3);
		wait_drained();
		write_reg(cct_pkg::REG_NUM_IN_STREAMS, kw);
		write_reg(cct_pkg::REG_NUM_OUT_BITS, nw);
		write_reg(cct_pkg::REG_GEN_OUT0, g0);
		write_reg(cct_pkg::REG_GEN_OUT1, g1);
		write_reg(cct_pkg::REG_GEN_OUT2, g2);
		write_reg(cct_pkg::REG_GEN_OUT3, g3);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [cct_pkg::CFG_DATA_W-1:0] random_gen_word();
		logic [cct_pkg::CFG_DATA_W-1:0] w;
		logic [cct_pkg::SLOT-1:0]       poly;
		int                             d;
		for (int j = 0; j < cct_pkg::MAX_STREAMS; j++) begin
			case ($urandom_range(0, 9))
				0:       poly = '0;
				1:       poly = '1;
				2:       poly = cct_pkg::SLOT'($urandom_range(0, 511))
					| (cct_pkg::SLOT'(1) << cct_pkg::MAX_DEGREE);
				default: begin
					d    = $urandom_range(0, cct_pkg::MAX_DEGREE);
					poly = cct_pkg::SLOT'($urandom_range(0, 511) & ((1 << (d + 1)) - 1));
					if ($urandom_range(0, 3) != 0)
						poly = poly | (cct_pkg::SLOT'(1) << d);
				end
			endcase
			w[j*cct_pkg::SLOT +: cct_pkg::SLOT] = poly;
		end
		return w;
	endfunction

	// stimulus
	initial begin
		int sent;
		int burst_len;
		code_k      = cct_pkg::RST_NUM_IN_STREAMS;
		code_n      = cct_pkg::RST_NUM_OUT_BITS;
		code_gen[0] = cct_pkg::RST_GEN_OUT0;
		code_gen[1] = cct_pkg::RST_GEN_OUT1;
		code_gen[2] = '0;
		code_gen[3] = '0;
		for (int j = 0; j < cct_pkg::MAX_STREAMS; j++)
			enc_reg[j] = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default code straight out of reset
		symbols_to_send.push_back(2'd1);
		symbols_to_send.push_back(2'd0);
		symbols_to_send.push_back(2'd1);
		symbols_to_send.push_back(2'd1);
		symbols_to_send.push_back(2'd0);
		symbols_to_send.push_back(2'd2);

		// two streams, four outputs, full depth everywhere
		load_code(18'd2, 18'd4, '1, '1, '1, '1);
		for (int s = 0; s < 4; s++)
			symbols_to_send.push_back(2'(s));
		symbols_to_send.push_back(2'd3);

		// zero counts clamp up, stream 1 and upper input bit unused
		load_code(18'h3FFFC, 18'h3FFF8, 18'h3FE01, 18'h2AAAA, 18'h15555, '1);
		symbols_to_send.push_back(2'd2);
		symbols_to_send.push_back(2'd3);
		symbols_to_send.push_back(2'd1);

		// oversized counts clamp down, short memory on a wide register
		load_code(18'd3, 18'd7, 18'h00103, {9'h005, 9'h000}, {9'h00B, 9'h001}, {9'h002, 9'h0FF});
		symbols_to_send.push_back(2'd3);
		symbols_to_send.push_back(2'd0);
		symbols_to_send.push_back(2'd2);
		symbols_to_send.push_back(2'd1);

		// stream 1 all zero over the active outputs
		load_code(18'd2, 18'd2, {9'h000, 9'h1FF}, {9'h000, 9'h0AB}, '1, '1);
		symbols_to_send.push_back(2'd3);
		symbols_to_send.push_back(2'd1);

		// single output with zero polynomial, later ones ignored
		load_code(18'd1, 18'd1, 18'd0, '1, '1, '1);
		symbols_to_send.push_back(2'd1);

		// registers held through the error
		load_code(18'd2, 18'd2, '1, 18'h2AAAA, '0, '0);
		symbols_to_send.push_back(2'd0);
		symbols_to_send.push_back(2'd1);

		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			load_code({16'($urandom), 2'($urandom_range(0, 3))},
				{15'($urandom), 3'($urandom_range(0, 7))},
				random_gen_word(), random_gen_word(), random_gen_word(), random_gen_word());
			burst_len = $urandom_range(40, 160);
			for (int i = 0; i < burst_len; i++)
				symbols_to_send.push_back(2'($urandom_range(0, 3)));
			sent += burst_len;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* conv_code_trellis_step_core.f */
+incdir+src
src/cct_pkg.sv
src/cct_step.sv
src/conv_code_trellis_step_core.sv
tb/conv_code_trellis_step_core_test.sv
